// File: design/scan_rate_detector_core_macros.svh
// Assertion macros shared by the scan rate detector checkers.
`ifndef SCAN_RATE_DETECTOR_CORE_MACROS_SVH
`define SCAN_RATE_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/srd_pkg.sv
// Shared types and constants of the scan rate detector.
`timescale 1ns / 1ps
package srd_pkg;

  localparam int unsigned LogDepthDef = 64;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned StampW   = 32;
  localparam int unsigned ThreshW  = 6;
  localparam int unsigned WindowW  = 8;
  localparam int unsigned CountW   = 7;
  localparam int unsigned InDataW  = AddrW + StampW;
  localparam int unsigned OutDataW = 1 + CountW;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgThreshold = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgWindow    = 8'd1;

  localparam logic [ThreshW-1:0] ThresholdRst = 6'd5;
  localparam logic [WindowW-1:0] WindowRst    = 8'd3;

  // One ring entry as stored in the log memory.
  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic [AddrW-1:0]  source;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } scan_state_e;

endpackage

// File: design/srd_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module srd_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/srd_match.sv
// Per-entry match test: same source and within the time window.
`timescale 1ns / 1ps
module srd_match (
  input  srd_pkg::entry_t              entry_i,
  input  logic                         qual_i,
  input  logic [srd_pkg::AddrW-1:0]    key_i,
  input  logic [srd_pkg::StampW-1:0]   now_i,
  input  logic [srd_pkg::WindowW-1:0]  window_i,
  output logic                         hit_o
);
  import srd_pkg::*;

  logic [StampW-1:0] age;
  logic              in_window;

  always_comb begin
    age = now_i - entry_i.stamp;
    // A stamp later than now counts as age zero.
    in_window = (entry_i.stamp > now_i) || (age <= {{(StampW-WindowW){1'b0}}, window_i});
  end

  assign hit_o = qual_i && (entry_i.source == key_i) && in_window;

endmodule

// File: design/srd_ctrl.sv
// Sequencer: ring write, log sweep, count accumulate and output register.
`timescale 1ns / 1ps
module srd_ctrl #(
  parameter int unsigned LogDepth = srd_pkg::LogDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [srd_pkg::AddrW-1:0]     in_src_i,
  input  logic [srd_pkg::StampW-1:0]    in_now_i,
  input  logic [srd_pkg::ThreshW-1:0]   threshold_i,
  output logic                          ram_we_o,
  output logic [$clog2(LogDepth)-1:0]   ram_waddr_o,
  output srd_pkg::entry_t               ram_wdata_o,
  output logic [$clog2(LogDepth)-1:0]   ram_raddr_o,
  output logic                          qual_o,
  output logic [srd_pkg::AddrW-1:0]     key_o,
  output logic [srd_pkg::StampW-1:0]    now_o,
  input  logic                          hit_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_alert_o,
  output logic [srd_pkg::CountW-1:0]    out_count_o
);
  import srd_pkg::*;

  localparam int unsigned SlotW = $clog2(LogDepth);
  localparam int unsigned CntW  = $clog2(LogDepth + 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(LogDepth - 1);

  scan_state_e state_q, state_d;

  logic [SlotW-1:0]  slot_q, cur_slot_q, addr_q, ridx_q;
  logic              full_q, rvalid_q;
  logic [CntW-1:0]   cnt_q;
  logic [AddrW-1:0]  src_q;
  logic [StampW-1:0] now_q;
  logic              out_valid_q, out_alert_q;
  logic [CountW-1:0] out_count_q;

  logic accept, rd_en, load_out, out_free;
  logic [CntW+CountW-1:0] cnt_ext, thr_ext;

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (addr_q == LastSlot) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SCAN:   rd_en      = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: load_out   = out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      cur_slot_q  <= '0;
      full_q      <= 1'b0;
      addr_q      <= '0;
      rvalid_q    <= 1'b0;
      ridx_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= rd_en;
      ridx_q   <= addr_q;
      if (accept) begin
        cur_slot_q <= slot_q;
        slot_q     <= (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
        if (slot_q == LastSlot) begin
          full_q <= 1'b1;
        end
        addr_q <= '0;
        cnt_q  <= '0;
      end else begin
        if (rd_en && (addr_q != LastSlot)) begin
          addr_q <= addr_q + 1'b1;
        end
        if (hit_i) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q <= in_src_i;
      now_q <= in_now_i;
    end
    if (load_out) begin
      out_alert_q <= (cnt_ext == thr_ext);
      out_count_q <= cnt_ext[CountW-1:0];
    end
  end

  assign cnt_ext = {{CountW{1'b0}}, cnt_q};
  assign thr_ext = {{CntW{1'b0}}, ({1'b0, threshold_i} + 7'd1)};

  // Ring fills in slot order, so an entry is live once full or at/below the newest slot.
  assign qual_o = rvalid_q && (full_q || (ridx_q <= cur_slot_q));
  assign key_o  = src_q;
  assign now_o  = now_q;

  assign ram_we_o           = accept;
  assign ram_waddr_o        = slot_q;
  assign ram_wdata_o.source = in_src_i;
  assign ram_wdata_o.stamp  = in_now_i;
  assign ram_raddr_o        = addr_q;

  assign out_valid_o = out_valid_q;
  assign out_alert_o = out_alert_q;
  assign out_count_o = out_count_q;

endmodule

// File: design/scan_rate_detector_core.sv
// Scan rate detector: per-event sliding-window count over a ring log of probes.
// A result is registered after the sweep of the log memory and the DRAIN and FINISH states.
// A new event is taken only when the core is idle again; the pace is set by the sweep of the log
// memory, one entry read per cycle through its single read port.
// A finished result waits in the output register while the next event is taken.
// Reset clears the fill flag and write slot (no memory clearing pass); config resets to 5 / 3.
`timescale 1ns / 1ps
module scan_rate_detector_core #(
  parameter int unsigned LogDepth = srd_pkg::LogDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [31:0] source_address, [63:32] event_time
  input  logic [srd_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] alert, [7:1] probe_count
  output logic [srd_pkg::OutDataW-1:0]   m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [srd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [srd_pkg::CfgDataW-1:0]   cfg_data_i
);
  import srd_pkg::*;

  localparam int unsigned SlotW = $clog2(LogDepth);

  logic [ThreshW-1:0] threshold_q;
  logic [WindowW-1:0] window_q;

  logic             ram_we, qual, hit, out_alert;
  logic [SlotW-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;
  logic [AddrW-1:0] key;
  logic [StampW-1:0] now;
  logic [CountW-1:0] out_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdRst;
      window_q    <= WindowRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgThreshold) begin
        threshold_q <= cfg_data_i[ThreshW-1:0];
      end else if (cfg_index_i == CfgWindow) begin
        window_q <= cfg_data_i[WindowW-1:0];
      end
    end
  end

  srd_ctrl #(
    .LogDepth(LogDepth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_src_i    (s_axis_tdata_i[AddrW-1:0]),
    .in_now_i    (s_axis_tdata_i[InDataW-1:AddrW]),
    .threshold_i (threshold_q),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .qual_o      (qual),
    .key_o       (key),
    .now_o       (now),
    .hit_i       (hit),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_alert_o (out_alert),
    .out_count_o (out_count)
  );

  srd_ram #(
    .Width(EntryW),
    .Depth(LogDepth)
  ) u_log (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  srd_match u_match (
    .entry_i  (ram_rdata),
    .qual_i   (qual),
    .key_i    (key),
    .now_i    (now),
    .window_i (window_q),
    .hit_o    (hit)
  );

  assign m_axis_tdata_o = {out_count, out_alert};

endmodule

// File: design/srd_checker.sv
// Port-level checker for the scan rate detector, bound to the top level.
`timescale 1ns / 1ps
`include "scan_rate_detector_core_macros.svh"
module srd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [srd_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                         cfg_ready_o
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  `SRD_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready_o, "config port not ready")
  `SRD_ASSERT_NEXT(a_busy_after_in, in_xfer, !s_axis_tready_o, "input taken during sweep")
  `SRD_ASSERT_NEXT(a_no_result_early, in_xfer, !m_axis_tvalid_o || !$rose(m_axis_tvalid_o),
                   "result raised right after input transfer")
  `SRD_ASSERT_NOW(a_alert_count, m_axis_tvalid_o && m_axis_tdata_o[0],
                  m_axis_tdata_o[srd_pkg::OutDataW-1:1] != '0, "alert with zero count")
  `SRD_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

endmodule

bind scan_rate_detector_core srd_checker u_srd_checker (.*);

// File: test/testbench.sv
// Self-checking testbench for the scan rate detector core.
`timescale 1ns / 1ps
module testbench;
  import srd_pkg::*;

  localparam int unsigned RingDepth  = LogDepthDef;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned IdlePct    = 27;
  localparam logic [CfgIdxW-1:0] CfgNoSuchReg = 8'd2;

  // Fields of one result, alert in bit 0.
  typedef struct packed {
    logic [CountW-1:0] probe_count;
    logic              alert;
  } verdict_t;

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;

  scan_rate_detector_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Shadow copy of the probe log and the registers.
  logic [AddrW-1:0]   log_source [RingDepth];
  logic [StampW-1:0]  log_stamp  [RingDepth];
  logic               log_used   [RingDepth];
  int unsigned        log_slot      = 0;
  logic [ThreshW-1:0] cur_threshold = ThresholdRst;
  logic [WindowW-1:0] cur_window    = WindowRst;

  verdict_t    pending_verdicts[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          steady_mode = 1'b0;
  int unsigned hold_ask    = 0;
  int unsigned hold_left   = 0;

  initial begin
    for (int i = 0; i < RingDepth; i++) log_used[i] = 1'b0;
  end

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Logs one probe and returns the count of same-source probes inside the window.
  function automatic verdict_t log_probe(logic [AddrW-1:0] addr, logic [StampW-1:0] stamp);
    verdict_t          v;
    int unsigned       hits;
    logic [StampW-1:0] age;
    log_source[log_slot] = addr;
    log_stamp[log_slot]  = stamp;
    log_used[log_slot]   = 1'b1;
    log_slot = (log_slot + 1 >= RingDepth) ? 0 : log_slot + 1;
    hits = 0;
    for (int i = 0; i < RingDepth; i++) begin
      if (log_used[i] && log_source[i] == addr) begin
        // a stamp later than now counts as age zero
        age = (log_stamp[i] > stamp) ? '0 : stamp - log_stamp[i];
        if (age <= StampW'(cur_window)) hits++;
      end
    end
    v.alert       = (hits == int'(cur_threshold) + 1);
    v.probe_count = CountW'(hits);
    return v;
  endfunction

  // Receiver: random stalls, or a long hold-off when one is asked for.
  always @(negedge clk_i) begin
    if (hold_ask != 0) begin
      hold_left = hold_ask;
      hold_ask  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= steady_mode || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    verdict_t got;
    verdict_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (pending_verdicts.size() == 0) begin
        $error("result transfer with no probe pending: tdata %h", m_axis_tdata_o);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.alert !== want.alert) begin
          $error("alert: expected %0d, got %0d", want.alert, got.alert);
          error_count++;
        end
        if (got.probe_count !== want.probe_count) begin
          $error("probe_count: expected %0d, got %0d", want.probe_count, got.probe_count);
          error_count++;
        end
      end
    end
  end

  // All drive tasks start and end at a falling edge.
  task automatic send_probe(input logic [AddrW-1:0] addr, input logic [StampW-1:0] stamp);
    while (!steady_mode && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {stamp, addr};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_verdicts.insert(pending_verdicts.size(), log_probe(addr, stamp));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Only called while the core is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgThreshold: cur_threshold = data[ThreshW-1:0];
      CfgWindow:    cur_window    = data;
      default:      ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_reset_config();
    repeat (6) send_probe(32'h0A0A_0A0A, 32'd1000);  // alert on the sixth
    send_probe(32'h0A0A_0A0A, 32'd1003);
    send_probe(32'h0A0A_0A0A, 32'd1004);
    send_probe(32'h0000_0000, 32'h0000_0000);
    send_probe(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_register_corners();
    write_reg(CfgNoSuchReg, 8'hA5);
    write_reg(CfgThreshold, 8'hC0);  // upper bits dropped: threshold zero
    write_reg(CfgWindow, 8'h00);
    send_probe(32'h0A00_0001, 32'd16);
    send_probe(32'h0A00_0001, 32'd16);
    send_probe(32'h0A00_0001, 32'd17);
    send_probe(32'h0A00_0001, 32'd5);    // time steps back
    wait_drained();
    write_reg(CfgThreshold, 8'hFF);
    write_reg(CfgWindow, 8'hFF);
    send_probe(32'hC0A8_0101, 32'h0000_0000);
    send_probe(32'hC0A8_0101, 32'hFFFF_FFFF);  // age far past any window
    send_probe(32'hC0A8_0101, 32'h0000_00FF);
    send_probe(32'hC0A8_0101, 32'h0000_0100);
    wait_drained();
  endtask

  // One busy source fills the whole log, so the count pins at the log depth.
  task automatic test_log_wrap();
    logic [AddrW-1:0]  addr;
    logic [StampW-1:0] stamp;
    addr  = $urandom();
    stamp = $urandom();
    write_reg(CfgThreshold, 8'(RingDepth - 1));
    write_reg(CfgWindow, 8'hFF);
    for (int i = 0; i < RingDepth + 16; i++) begin
      if ($urandom_range(0, 7) == 0) stamp++;
      send_probe(addr, stamp);
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    logic [StampW-1:0] stamp;
    stamp = $urandom();
    write_reg(CfgThreshold, 8'd2);
    write_reg(CfgWindow, 8'd10);
    hold_ask = 400;
    for (int i = 0; i < 16; i++) begin
      stamp += $urandom_range(0, 1);
      send_probe({31'h1234_5678, 1'($urandom())}, stamp);
    end
    wait_drained();
  endtask

  task automatic test_back_to_back();
    logic [StampW-1:0] stamp;
    stamp = $urandom();
    write_reg(CfgThreshold, 8'd3);
    write_reg(CfgWindow, 8'd5);
    steady_mode = 1'b1;
    for (int i = 0; i < 150; i++) begin
      stamp += $urandom_range(0, 2);
      send_probe(32'h0A01_0000 | 32'($urandom_range(0, 3)), stamp);
    end
    wait_drained();
    steady_mode = 1'b0;
  endtask

  // Phases of mostly well-behaved traffic from a few hosts, with some noise.
  task automatic test_random_phases();
    logic [AddrW-1:0]   hosts [6];
    logic [AddrW-1:0]   addr;
    logic [StampW-1:0]  cursor;
    logic [ThreshW-1:0] thr;
    logic [WindowW-1:0] win;
    int unsigned        roll;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin thr = 6'd1;  win = 8'd0;   end
        1: begin thr = 6'd63; win = 8'd255; end
        2: begin thr = 6'd0;  win = 8'd3;   end
        3: begin thr = 6'd2;  win = 8'd1;   end
        6: begin thr = ThreshW'($urandom()); win = WindowW'($urandom()); end
        default: begin
          thr = ThreshW'($urandom_range(1, 8));
          win = WindowW'($urandom_range(0, 20));
        end
      endcase
      write_reg(CfgThreshold, {2'($urandom()), thr});
      write_reg(CfgWindow, win);
      foreach (hosts[h]) hosts[h] = $urandom();
      cursor = $urandom();
      for (int i = 0; i < 200; i++) begin
        roll = $urandom_range(0, 99);
        addr = (roll < 90) ? hosts[$urandom_range(0, 5)] : $urandom();
        roll = $urandom_range(0, 99);
        if (roll < 70)      cursor += $urandom_range(0, 1);
        else if (roll < 90) cursor += $urandom_range(0, 2 * int'(win) + 2);
        else if (roll < 96) cursor -= $urandom_range(1, 300);
        else                cursor = $urandom();
        send_probe(addr, cursor);
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_config();
    test_register_corners();
    test_log_wrap();
    test_output_backpressure();
    test_back_to_back();
    test_random_phases();
    wait_drained();
    repeat (2 * (RingDepth + 3)) @(negedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $error("%0d results never arrived", pending_verdicts.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: scan_rate_detector_core.f
+incdir+design
design/srd_pkg.sv
design/srd_ram.sv
design/srd_match.sv
design/srd_ctrl.sv
design/scan_rate_detector_core.sv
design/srd_checker.sv
test/testbench.sv
